// ===== src/periodic_task_timer_bank_assert.svh =====
// Assertion macros shared by the timer bank RTL.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef PERIODIC_TASK_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TASK_TIMER_BANK_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define PTB_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("timer bank assertion failed");

// The consequence must hold in the cycle after the condition.
`define PTB_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("timer bank assertion failed");

`endif

// ===== src/ptb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

   localparam int OPCODE_W  = 2;
   localparam int HANDLER_W = 8;
   localparam int PERIOD_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 3;
   localparam int FIRED_W   = 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK     = 2'd0,
      OP_REGISTER = 2'd1,
      OP_CLEAR    = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== src/ptb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptb_req_if;
   import ptb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [HANDLER_W-1:0] handler_id;
   logic [PERIOD_W-1:0]  period_ticks;

   modport source (output valid, output opcode, output handler_id, output period_ticks,
                   input ready);
   modport sink   (input valid, input opcode, input handler_id, input period_ticks,
                   output ready);
endinterface

`default_nettype wire

// ===== src/ptb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptb_rsp_if;
   import ptb_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [FIRED_W-1:0]  fired_mask;

   modport source (output valid, output status, output slot_index, output fired_mask,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input fired_mask,
                   output ready);
endinterface

`default_nettype wire

// ===== src/periodic_task_timer_bank.sv =====
// Channel   Role     Carries
// req_bus   sink     opcode, handler_id, period_ticks
// rsp_bus   source   status, slot_index, fired_mask
//
// A register request or an unused opcode goes from idle straight to the finish state; a tick
// or a clear walks the slot memory one slot per cycle first. The finish state loads the
// result register once it is free; a new item is taken only back in idle after that. Reset
// clears the active bits, the controller and the result valid; the slot memory needs no clearing
// because an entry is only read while its slot is active. A stalled result holds in the output
// register; the next item is taken while it waits and its own result waits in the finish state.
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_task_timer_bank_assert.svh"

module periodic_task_timer_bank #(
   parameter int SLOTS      = 8,
   parameter int COUNT_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ptb_req_if.sink    req_bus,
   ptb_rsp_if.source  rsp_bus
);
   import ptb_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // One memory word holds everything a slot needs apart from its active bit.
   typedef struct packed {
      logic [HANDLER_W-1:0]  handler;
      logic [COUNT_BITS-1:0] period;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Controller and work registers.
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic                  sweep_clear_ff, sweep_clear_in;
   logic [HANDLER_W-1:0]  hid_ff, hid_in;
   logic [SLOTS-1:0]      active_ff, active_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [FIRED_W-1:0]    fired_ff, fired_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [FIRED_W-1:0]    rsp_fired_ff, rsp_fired_in;

   // Slot memory.
   entry_type             slot_mem [SLOTS];
   entry_type             rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   // Helpers.
   logic                  req_fire;
   logic                  out_free;
   logic                  last_slot;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [COUNT_BITS-1:0] cnt_dec;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign last_slot = (cur_ff == IDX_W'(SLOTS - 1));
   assign cnt_dec   = rd_data_ff.count - COUNT_BITS'(1);

   // Lowest-numbered free slot for a register request.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.opcode == OP_TICK || req_bus.opcode == OP_CLEAR) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SWEEP: begin
            if (last_slot) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cur_in         = cur_ff;
      sweep_clear_in = sweep_clear_ff;
      hid_in         = hid_ff;
      active_in      = active_ff;
      status_in      = status_ff;
      slot_in        = slot_ff;
      fired_in       = fired_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = rd_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_fired_in   = rsp_fired_ff;
      req_bus.ready  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire) begin
               cur_in         = '0;
               hid_in         = req_bus.handler_id;
               sweep_clear_in = (req_bus.opcode == OP_CLEAR);
               status_in      = STATUS_OK;
               slot_in        = '0;
               fired_in       = '0;
               case (req_bus.opcode)
                  OP_REGISTER: begin
                     if (free_found) begin
                        wr_en              = 1'b1;
                        wr_addr            = free_idx;
                        wr_data.handler    = req_bus.handler_id;
                        wr_data.period     = COUNT_BITS'(req_bus.period_ticks);
                        wr_data.count      = COUNT_BITS'(req_bus.period_ticks);
                        active_in[free_idx] = 1'b1;
                        slot_in            = SLOT_W'(free_idx);
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  OP_CLEAR: begin
                     status_in = STATUS_NOT_FOUND;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // rd_data_ff holds the entry of slot cur_ff; fetch the next one.
            rd_addr = cur_ff + IDX_W'(1);
            if (!last_slot) begin
               cur_in = cur_ff + IDX_W'(1);
            end
            if (active_ff[cur_ff]) begin
               if (sweep_clear_ff) begin
                  if (rd_data_ff.handler == hid_ff) begin
                     active_in[cur_ff] = 1'b0;
                     status_in         = STATUS_OK;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (cnt_dec == '0) begin
                     wr_data.count = rd_data_ff.period;
                     fired_in      = fired_ff | (FIRED_W'(1) << cur_ff);
                  end else begin
                     wr_data.count = cnt_dec;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff;
               rsp_fired_in  = fired_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.slot_index = rsp_slot_ff;
   assign rsp_bus.fired_mask = rsp_fired_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   // Payload and work registers.
   always_ff @(posedge clock) begin
      sweep_clear_ff <= sweep_clear_in;
      hid_ff         <= hid_in;
      status_ff      <= status_in;
      slot_ff        <= slot_in;
      fired_ff       <= fired_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_fired_ff   <= rsp_fired_in;
   end

   // Slot memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   // A register request never overwrites a slot that is already in use.
   `PTB_ASSERT_SAME(a_claim_free, clock, reset, wr_en && state_ff == ST_IDLE,
                    !active_ff[wr_addr])
   // A sweep steps through the slots one per cycle.
   `PTB_ASSERT_NEXT(a_sweep_step, clock, reset, state_ff == ST_SWEEP && !last_slot,
                    state_ff == ST_SWEEP && cur_ff == $past(cur_ff) + IDX_W'(1))
   // A clear sweep can only release slots, never activate one.
   `PTB_ASSERT_NEXT(a_clear_release, clock, reset, state_ff == ST_SWEEP && sweep_clear_ff,
                    (active_ff & ~$past(active_ff)) == '0)
   // A finished item is handed to the result register as soon as it frees.
   `PTB_ASSERT_NEXT(a_finish_load, clock, reset, state_ff == ST_FINISH && out_free,
                    rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire
